FILE: rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion lbl failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion lbl failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/rfr_pkg.sv
package rfr_pkg;

  localparam int IN_W    = 32;
  localparam int MAG_W   = IN_W + 1;
  localparam int RAD_W   = 2 * MAG_W;
  localparam int ROOT_W  = MAG_W;
  localparam int SREM_W  = ROOT_W + 2;
  localparam int QUO_W   = 31;
  localparam int DREM_W  = ROOT_W;
  localparam int RES_W   = 48;
  localparam int CHI_W   = 64;
  localparam int GRAD_W  = 32;
  localparam int HALF_W  = 17;
  localparam int R2_W    = 4 * HALF_W;
  localparam int R2H_W   = 2 * HALF_W;
  localparam int PP_W    = R2H_W + IN_W;
  localparam int PROD_W  = R2_W + IN_W;
  localparam int FRAC_SH = 16;

  typedef struct packed {
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ux;
    logic [MAG_W-1:0] uy;
    logic [IN_W-1:0]  off;
    logic [IN_W-1:0]  meas;
    logic [IN_W-1:0]  w;
  } sq_pl_t;

  typedef struct packed {
    logic             sx;
    logic             sy;
    logic             coinc;
    logic [RES_W-1:0] pred;
    logic [RES_W-1:0] res;
    logic [IN_W-1:0]  w;
  } dv_pl_t;

endpackage

FILE: rtl/range_factor_residual_unit.sv
// done_o is registered through the front stages, the square root row, the divider row and the tail
// throughput: one transaction per cycle, busy is never raised
// the 33-cell square root row and the 31-cell divider row make up most of the latency
// results leave on a one-cycle strobe, the receiver cannot stall
// reset: asynchronous active low, clears every valid bit in the pipeline
`include "assert_macros.svh"
module range_factor_residual_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           robot_x_i,
  input  logic signed [31:0]           robot_y_i,
  input  logic signed [31:0]           beacon_x_i,
  input  logic signed [31:0]           beacon_y_i,
  input  logic signed [31:0]           beacon_offset_i,
  input  logic signed [31:0]           measured_range_i,
  input  logic [31:0]                  weight_i,
  output logic                         done_o,
  output logic signed [47:0]           predicted_range_o,
  output logic signed [47:0]           residual_o,
  output logic [63:0]                  chi_square_o,
  output logic signed [31:0]           grad_x_o,
  output logic signed [31:0]           grad_y_o,
  output logic                         coincident_o,
  output logic                         chi_saturated_o
);
  import rfr_pkg::*;

  localparam int SQ_N = ROOT_W;
  localparam int DV_N = QUO_W;
  localparam int SQ_PW = $bits(sq_pl_t);
  localparam int DV_PW = $bits(dv_pl_t);

  assign busy = 1'b0;

  // front: differences, squares, sum
  logic             v0_q, v1_q, v2_q;
  sq_pl_t           pl0_d, pl0_q, pl1_q, pl2_q;
  logic [MAG_W-1:0] dx, dy;
  logic [RAD_W-1:0] sqx_q, sqy_q, n_q;

  always_comb begin
    dx = {robot_x_i[IN_W-1], robot_x_i} - {beacon_x_i[IN_W-1], beacon_x_i};
    dy = {robot_y_i[IN_W-1], robot_y_i} - {beacon_y_i[IN_W-1], beacon_y_i};
    pl0_d.sx   = dx[MAG_W-1];
    pl0_d.sy   = dy[MAG_W-1];
    pl0_d.ux   = dx[MAG_W-1] ? (~dx + 1'b1) : dx;
    pl0_d.uy   = dy[MAG_W-1] ? (~dy + 1'b1) : dy;
    pl0_d.off  = beacon_offset_i;
    pl0_d.meas = measured_range_i;
    pl0_d.w    = weight_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pl0_q <= pl0_d;
    sqx_q <= RAD_W'(pl0_q.ux) * RAD_W'(pl0_q.ux);
    sqy_q <= RAD_W'(pl0_q.uy) * RAD_W'(pl0_q.uy);
    pl1_q <= pl0_q;
    n_q   <= sqx_q + sqy_q;
    pl2_q <= pl1_q;
  end

  // square root row
  logic              sq_v    [0:SQ_N];
  logic [RAD_W-1:0]  sq_rad  [0:SQ_N];
  logic [ROOT_W-1:0] sq_root [0:SQ_N];
  logic [SREM_W-1:0] sq_rem  [0:SQ_N];
  logic [SQ_PW-1:0]  sq_pl   [0:SQ_N];

  assign sq_v[0]    = v2_q;
  assign sq_rad[0]  = n_q;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_pl[0]   = pl2_q;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    rfr_sqrt_cell #(.PW(SQ_PW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .rad_i   (sq_rad[i]),
      .root_i  (sq_root[i]),
      .rem_i   (sq_rem[i]),
      .pl_i    (sq_pl[i]),
      .valid_o (sq_v[i+1]),
      .rad_o   (sq_rad[i+1]),
      .root_o  (sq_root[i+1]),
      .rem_o   (sq_rem[i+1]),
      .pl_o    (sq_pl[i+1])
    );
  end

  // predicted range and residual
  sq_pl_t            sq_out;
  logic              vr_q;
  dv_pl_t            plr_q;
  logic [MAG_W-1:0]  uxr_q, uyr_q;
  logic [ROOT_W-1:0] dr_q;
  logic [RES_W-1:0]  pred_d;

  always_comb begin
    sq_out = sq_pl[SQ_N];
    pred_d = RES_W'(sq_root[SQ_N])
           + {{(RES_W-IN_W){sq_out.off[IN_W-1]}}, sq_out.off};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else begin
      vr_q <= sq_v[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    plr_q.sx    <= sq_out.sx;
    plr_q.sy    <= sq_out.sy;
    plr_q.coinc <= (sq_root[SQ_N] == '0);
    plr_q.pred  <= pred_d;
    plr_q.res   <= {{(RES_W-IN_W){sq_out.meas[IN_W-1]}}, sq_out.meas} - pred_d;
    plr_q.w     <= sq_out.w;
    uxr_q       <= sq_out.ux;
    uyr_q       <= sq_out.uy;
    dr_q        <= sq_root[SQ_N];
  end

  // divider row, both gradients share the divisor
  logic              dv_v    [0:DV_N];
  logic [DREM_W-1:0] dv_d    [0:DV_N];
  logic [DREM_W-1:0] dv_remx [0:DV_N];
  logic [DREM_W-1:0] dv_remy [0:DV_N];
  logic [QUO_W-1:0]  dv_numx [0:DV_N];
  logic [QUO_W-1:0]  dv_numy [0:DV_N];
  logic [QUO_W-1:0]  dv_qx   [0:DV_N];
  logic [QUO_W-1:0]  dv_qy   [0:DV_N];
  logic [DV_PW-1:0]  dv_pl   [0:DV_N];

  // numerator is |delta| << 30, its upper bits already sit below the divisor
  assign dv_v[0]    = vr_q;
  assign dv_d[0]    = dr_q;
  assign dv_remx[0] = {1'b0, uxr_q[MAG_W-1:1]};
  assign dv_remy[0] = {1'b0, uyr_q[MAG_W-1:1]};
  assign dv_numx[0] = {uxr_q[0], {(QUO_W-1){1'b0}}};
  assign dv_numy[0] = {uyr_q[0], {(QUO_W-1){1'b0}}};
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;
  assign dv_pl[0]   = plr_q;

  for (genvar j = 0; j < DV_N; j++) begin : g_div
    rfr_div_cell #(.PW(DV_PW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[j]),
      .dvsr_i  (dv_d[j]),
      .remx_i  (dv_remx[j]),
      .remy_i  (dv_remy[j]),
      .numx_i  (dv_numx[j]),
      .numy_i  (dv_numy[j]),
      .qx_i    (dv_qx[j]),
      .qy_i    (dv_qy[j]),
      .pl_i    (dv_pl[j]),
      .valid_o (dv_v[j+1]),
      .dvsr_o  (dv_d[j+1]),
      .remx_o  (dv_remx[j+1]),
      .remy_o  (dv_remy[j+1]),
      .numx_o  (dv_numx[j+1]),
      .numy_o  (dv_numy[j+1]),
      .qx_o    (dv_qx[j+1]),
      .qy_o    (dv_qy[j+1]),
      .pl_o    (dv_pl[j+1])
    );
  end

  // chi-square tail
  dv_pl_t            dv_out;
  logic [RES_W-1:0]  res_abs;
  logic [GRAD_W-1:0] gx_d, gy_d;
  logic              vc1_q, vc2_q, vc3_q, vc4_q;
  logic [R2H_W-1:0]  p11_q, p10_q, p00_q;
  logic [R2_W-1:0]   r2_q;
  logic [PP_W-1:0]   ph_q, pl_q;
  logic [PROD_W-1:0] prod;
  logic              sat_d;
  logic [RES_W-1:0]  pred_c1_q, pred_c2_q, pred_c3_q;
  logic [RES_W-1:0]  res_c1_q, res_c2_q, res_c3_q;
  logic [IN_W-1:0]   w_c1_q, w_c2_q;
  logic [GRAD_W-1:0] gx_c1_q, gx_c2_q, gx_c3_q, gy_c1_q, gy_c2_q, gy_c3_q;
  logic              co_c1_q, co_c2_q, co_c3_q;

  always_comb begin
    dv_out  = dv_pl[DV_N];
    res_abs = dv_out.res[RES_W-1] ? (~dv_out.res + 1'b1) : dv_out.res;
    gx_d    = dv_out.sx ? (~GRAD_W'(dv_qx[DV_N]) + 1'b1) : GRAD_W'(dv_qx[DV_N]);
    gy_d    = dv_out.sy ? (~GRAD_W'(dv_qy[DV_N]) + 1'b1) : GRAD_W'(dv_qy[DV_N]);
    if (dv_out.coinc) begin
      gx_d = '0;
      gy_d = '0;
    end
    prod  = (PROD_W'(ph_q) << R2H_W) + PROD_W'(pl_q);
    sat_d = |prod[PROD_W-1:CHI_W+FRAC_SH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc1_q <= 1'b0;
      vc2_q <= 1'b0;
      vc3_q <= 1'b0;
      vc4_q <= 1'b0;
    end else begin
      vc1_q <= dv_v[DV_N];
      vc2_q <= vc1_q;
      vc3_q <= vc2_q;
      vc4_q <= vc3_q;
    end
  end

  // |residual| stays below 2^34, split into two 17-bit halves
  always_ff @(posedge clk_i) begin
    p11_q     <= R2H_W'(res_abs[R2H_W-1:HALF_W]) * R2H_W'(res_abs[R2H_W-1:HALF_W]);
    p10_q     <= R2H_W'(res_abs[R2H_W-1:HALF_W]) * R2H_W'(res_abs[HALF_W-1:0]);
    p00_q     <= R2H_W'(res_abs[HALF_W-1:0]) * R2H_W'(res_abs[HALF_W-1:0]);
    pred_c1_q <= dv_out.pred;
    res_c1_q  <= dv_out.res;
    w_c1_q    <= dv_out.w;
    gx_c1_q   <= gx_d;
    gy_c1_q   <= gy_d;
    co_c1_q   <= dv_out.coinc;

    r2_q      <= (R2_W'(p11_q) << R2H_W) + (R2_W'(p10_q) << (HALF_W + 1)) + R2_W'(p00_q);
    pred_c2_q <= pred_c1_q;
    res_c2_q  <= res_c1_q;
    w_c2_q    <= w_c1_q;
    gx_c2_q   <= gx_c1_q;
    gy_c2_q   <= gy_c1_q;
    co_c2_q   <= co_c1_q;

    ph_q      <= PP_W'(r2_q[R2_W-1:R2H_W]) * PP_W'(w_c2_q);
    pl_q      <= PP_W'(r2_q[R2H_W-1:0]) * PP_W'(w_c2_q);
    pred_c3_q <= pred_c2_q;
    res_c3_q  <= res_c2_q;
    gx_c3_q   <= gx_c2_q;
    gy_c3_q   <= gy_c2_q;
    co_c3_q   <= co_c2_q;

    predicted_range_o <= pred_c3_q;
    residual_o        <= res_c3_q;
    chi_square_o      <= sat_d ? {CHI_W{1'b1}} : prod[CHI_W+FRAC_SH-1:FRAC_SH];
    chi_saturated_o   <= sat_d;
    grad_x_o          <= gx_c3_q;
    grad_y_o          <= gy_c3_q;
    coincident_o      <= co_c3_q;
  end

  assign done_o = vc4_q;

  `ASSERT_IMPL(a_coinc_zero_grad, clk_i, rst_ni, done_o && coincident_o, grad_x_o == '0 && grad_y_o == '0)
  `ASSERT_IMPL(a_sat_clamps, clk_i, rst_ni, done_o && chi_saturated_o, chi_square_o == {CHI_W{1'b1}})
  `ASSERT_IMPL(a_grad_bound, clk_i, rst_ni, done_o, grad_x_o <= 32'sd1073741824 && grad_x_o >= -32'sd1073741824)
  `ASSERT_NEXT(a_tail_flow, clk_i, rst_ni, dv_v[DV_N], vc1_q)

endmodule

FILE: rtl/rfr_sqrt_cell.sv
module rfr_sqrt_cell #(
  parameter int PW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rfr_pkg::RAD_W-1:0]   rad_i,
  input  logic [rfr_pkg::ROOT_W-1:0]  root_i,
  input  logic [rfr_pkg::SREM_W-1:0]  rem_i,
  input  logic [PW-1:0]               pl_i,
  output logic                        valid_o,
  output logic [rfr_pkg::RAD_W-1:0]   rad_o,
  output logic [rfr_pkg::ROOT_W-1:0]  root_o,
  output logic [rfr_pkg::SREM_W-1:0]  rem_o,
  output logic [PW-1:0]               pl_o
);
  import rfr_pkg::*;

  logic [SREM_W+1:0] acc, trial, diff;
  logic              ge;
  logic [SREM_W-1:0] rem_d;
  logic [ROOT_W-1:0] root_d;

  // one root bit per cell, two radicand bits brought down
  always_comb begin
    acc    = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    diff   = acc - trial;
    ge     = (acc >= trial);
    rem_d  = ge ? diff[SREM_W-1:0] : acc[SREM_W-1:0];
    root_d = {root_i[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_o  <= {rad_i[RAD_W-3:0], 2'b00};
    root_o <= root_d;
    rem_o  <= rem_d;
    pl_o   <= pl_i;
  end

endmodule

FILE: rtl/rfr_div_cell.sv
module rfr_div_cell #(
  parameter int PW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rfr_pkg::DREM_W-1:0]  dvsr_i,
  input  logic [rfr_pkg::DREM_W-1:0]  remx_i,
  input  logic [rfr_pkg::DREM_W-1:0]  remy_i,
  input  logic [rfr_pkg::QUO_W-1:0]   numx_i,
  input  logic [rfr_pkg::QUO_W-1:0]   numy_i,
  input  logic [rfr_pkg::QUO_W-1:0]   qx_i,
  input  logic [rfr_pkg::QUO_W-1:0]   qy_i,
  input  logic [PW-1:0]               pl_i,
  output logic                        valid_o,
  output logic [rfr_pkg::DREM_W-1:0]  dvsr_o,
  output logic [rfr_pkg::DREM_W-1:0]  remx_o,
  output logic [rfr_pkg::DREM_W-1:0]  remy_o,
  output logic [rfr_pkg::QUO_W-1:0]   numx_o,
  output logic [rfr_pkg::QUO_W-1:0]   numy_o,
  output logic [rfr_pkg::QUO_W-1:0]   qx_o,
  output logic [rfr_pkg::QUO_W-1:0]   qy_o,
  output logic [PW-1:0]               pl_o
);
  import rfr_pkg::*;

  logic [DREM_W:0]   tx, ty, dx_diff, dy_diff, dv;
  logic              gex, gey;
  logic [DREM_W-1:0] remx_d, remy_d;

  // restoring division, one quotient bit per lane per cell
  always_comb begin
    dv      = {1'b0, dvsr_i};
    tx      = {remx_i, numx_i[QUO_W-1]};
    ty      = {remy_i, numy_i[QUO_W-1]};
    dx_diff = tx - dv;
    dy_diff = ty - dv;
    gex     = (tx >= dv);
    gey     = (ty >= dv);
    remx_d  = gex ? dx_diff[DREM_W-1:0] : tx[DREM_W-1:0];
    remy_d  = gey ? dy_diff[DREM_W-1:0] : ty[DREM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dvsr_o <= dvsr_i;
    remx_o <= remx_d;
    remy_o <= remy_d;
    numx_o <= {numx_i[QUO_W-2:0], 1'b0};
    numy_o <= {numy_i[QUO_W-2:0], 1'b0};
    qx_o   <= {qx_i[QUO_W-2:0], gex};
    qy_o   <= {qy_i[QUO_W-2:0], gey};
    pl_o   <= pl_i;
  end

endmodule
